// ===== hdl/fsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared constants, types and tables for the fuzzy speed controller.
// ----------------------------------------------------------------------------
package fsc_pkg;

    localparam int CurveLo    = 100;
    localparam int CurveHi    = 250;
    localparam int BlankMax   = 50;
    localparam int RowBase    = 144;
    localparam int WeightFull = 100;
    localparam int PointStep  = 16;

    localparam int NumW   = 18;   // sum of four 7x9-bit products
    localparam int DenW   = 9;    // sum of four weights
    localparam int SpeedW = 9;

    typedef logic [2:0] label_t;
    typedef logic [6:0] weight_t;

    typedef struct packed {
        logic [2:0] seg;
        weight_t    low_w;
    } member_t;

    typedef struct packed {
        logic [NumW-1:0] num;
        logic [DenW-1:0] den;
    } div_in_t;

    // Triangular membership over seven points 16 apart.
    function automatic member_t membership(logic [6:0] x);
        member_t    res;
        logic [7:0] xs;
        logic [2:0] n;
        logic [3:0] r;
        logic [10:0] prod;
        xs   = {1'b0, x} + 8'(PointStep - 1);
        n    = xs[6:4];
        r    = 4'({n, 4'b0000} - x);
        prod = 11'(r) * 11'(WeightFull);
        if (x == 7'd0) begin
            res.seg   = 3'd1;
            res.low_w = weight_t'(WeightFull);
        end else if (x >= 7'(6 * PointStep)) begin
            res.seg   = 3'd6;
            res.low_w = '0;
        end else begin
            res.seg   = n;
            res.low_w = prod[10:4];
        end
        return res;
    endfunction

    // Output label of the 7x7 rule table.
    function automatic label_t rule_label(logic [2:0] row, logic [2:0] col);
        logic [20:0] line;
        case (row)
            3'd0: line = {3'd1, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6};
            3'd1: line = {3'd1, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd5};
            3'd2: line = {3'd0, 3'd1, 3'd1, 3'd2, 3'd3, 3'd4, 3'd4};
            3'd3: line = {3'd0, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3, 3'd3};
            3'd4: line = {3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2};
            3'd5: line = {3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2};
            3'd6: line = {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1};
            default: line = '0;
        endcase
        case (col)
            3'd0: return line[2:0];
            3'd1: return line[5:3];
            3'd2: return line[8:6];
            3'd3: return line[11:9];
            3'd4: return line[14:12];
            3'd5: return line[17:15];
            3'd6: return line[20:18];
            default: return '0;
        endcase
    endfunction

    // Singleton speed level of a label in one of four tables.
    function automatic logic [8:0] speed_level(logic [1:0] sel, label_t lab);
        logic [62:0] row;
        case (sel)
            2'd0: row = {9'd380, 9'd350, 9'd295, 9'd275, 9'd270, 9'd260, 9'd250};
            2'd1: row = {9'd400, 9'd360, 9'd300, 9'd290, 9'd275, 9'd270, 9'd260};
            2'd2: row = {9'd430, 9'd380, 9'd310, 9'd300, 9'd285, 9'd275, 9'd265};
            default: row = {9'd440, 9'd390, 9'd320, 9'd305, 9'd285, 9'd275, 9'd270};
        endcase
        case (lab)
            3'd1: return row[17:9];
            3'd2: return row[26:18];
            3'd3: return row[35:27];
            3'd4: return row[44:36];
            3'd5: return row[53:45];
            3'd6: return row[62:54];
            default: return row[8:0];   // label 0, and 7 wraps to 0
        endcase
    endfunction

endpackage

// ===== hdl/fsc_div.sv =====
// ----------------------------------------------------------------------------
// fsc_div
// Three-stage pipelined restoring divider, three quotient bits per stage.
// ----------------------------------------------------------------------------
module fsc_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  fsc_pkg::div_in_t            in_data,
    output logic                        out_valid,
    output logic [fsc_pkg::SpeedW-1:0]  quotient
);

    localparam int Stages = 3;
    localparam int Bits   = 3;

    typedef struct packed {
        logic [fsc_pkg::DenW-1:0] rem;
        logic [fsc_pkg::DenW-1:0] q3;
    } step_t;

    // Retire three quotient bits; rem stays below den.
    function automatic step_t div_step(logic [8:0] rem_in, logic [2:0] bits,
                                       logic [8:0] den);
        step_t      res;
        logic [9:0] t;
        logic [8:0] r;
        r      = rem_in;
        res.q3 = '0;
        for (int i = Bits - 1; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= {1'b0, den}) begin
                t = t - {1'b0, den};
                res.q3[i] = 1'b1;
            end
            r = t[8:0];
        end
        res.rem = r;
        return res;
    endfunction

    logic                        valid_reg [Stages];
    logic [fsc_pkg::DenW-1:0]    rem_reg   [Stages];
    logic [fsc_pkg::NumW-1:0]    num_reg   [Stages];
    logic [fsc_pkg::DenW-1:0]    den_reg   [Stages];
    logic [fsc_pkg::SpeedW-1:0]  q_reg     [Stages];

    genvar s;
    generate
        for (s = 0; s < Stages; s++) begin : g_stage
            logic                       valid_src;
            logic [fsc_pkg::DenW-1:0]   rem_src;
            logic [fsc_pkg::NumW-1:0]   num_src;
            logic [fsc_pkg::DenW-1:0]   den_src;
            logic [fsc_pkg::SpeedW-1:0] q_src;
            logic [fsc_pkg::SpeedW-1:0] q_next;
            step_t                      st;

            if (s == 0) begin : g_first
                assign valid_src = in_valid;
                assign rem_src   = in_data.num[17:9];
                assign num_src   = in_data.num;
                assign den_src   = in_data.den;
                assign q_src     = '0;
            end else begin : g_rest
                assign valid_src = valid_reg[s-1];
                assign rem_src   = rem_reg[s-1];
                assign num_src   = num_reg[s-1];
                assign den_src   = den_reg[s-1];
                assign q_src     = q_reg[s-1];
            end

            always_comb
            begin
                st     = div_step(rem_src, num_src[8-Bits*s -: Bits], den_src);
                q_next = q_src;
                q_next[8-Bits*s -: Bits] = st.q3[Bits-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n) begin
                    valid_reg[s] <= 1'b0;
                end else begin
                    valid_reg[s] <= valid_src;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[s] <= st.rem;
                num_reg[s] <= num_src;
                den_reg[s] <= den_src;
                q_reg[s]   <= q_next;
            end
        end
    endgenerate

    // Zero total strength answers zero.
    assign out_valid = valid_reg[Stages-1];
    assign quotient  = (den_reg[Stages-1] == '0) ? '0 : q_reg[Stages-1];

    a_valid_delay: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, Stages))
        else $error("divider valid does not match input three cycles earlier");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && den_reg[0] != '0) |-> (rem_reg[0] < den_reg[0]))
        else $error("partial remainder not below divisor");

    a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && den_reg[Stages-1] == '0) |-> (quotient == '0))
        else $error("zero divisor must give zero quotient");

endmodule

// ===== hdl/fuzzy_speed_controller.sv =====
// ----------------------------------------------------------------------------
// fuzzy_speed_controller
// Throughput: one item per cycle; busy stays low, every start is taken.
// Depth is set by the scaling, membership, rule, product, sum stages and the
// three divider stages. Results cannot be held off by the receiver.
// Reset clears all valid bits and sets the table select to 0.
// ----------------------------------------------------------------------------
module fuzzy_speed_controller
(
    input  logic               clk,
    input  logic               rst_n,
    // item channel
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] curve_measure,
    input  logic [7:0]         row_count,
    // result
    output logic               done,
    output logic [8:0]         speed,
    // configuration: level table select
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_data
);

    // The pipeline never stalls, so both ports always accept.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    logic [1:0] table_sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            table_sel_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            table_sel_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: clamp and scale both inputs to 0..100.
    // p = floor(2x/3) with x = c - 100 in 0..150, done as 2x*683 >> 11.
    // ------------------------------------------------------------------
    logic        v1_reg;
    logic [6:0]  p1_reg, p1_next;
    logic [6:0]  d1_reg, d1_next;
    logic [7:0]  x_off;
    logic [15:0] c_diff;
    logic [18:0] p_prod;
    logic [7:0]  blank;

    always_comb
    begin
        c_diff = 16'(curve_measure - 16'sd100);
        if (curve_measure < 16'(fsc_pkg::CurveLo)) begin
            x_off = '0;
        end else if (curve_measure > 16'(fsc_pkg::CurveHi)) begin
            x_off = 8'(fsc_pkg::CurveHi - fsc_pkg::CurveLo);
        end else begin
            x_off = c_diff[7:0];
        end
        p_prod  = 19'({x_off, 1'b0}) * 19'd683;
        p1_next = p_prod[17:11];

        if (row_count >= 8'(fsc_pkg::RowBase)) begin
            blank = '0;
        end else begin
            blank = 8'(fsc_pkg::RowBase) - row_count;
        end
        if (blank > 8'(fsc_pkg::BlankMax)) begin
            blank = 8'(fsc_pkg::BlankMax);
        end
        d1_next = {blank[5:0], 1'b0};
    end

    // ------------------------------------------------------------------
    // Stage 2: membership of both values and the four rule labels.
    // ------------------------------------------------------------------
    logic                    v2_reg;
    fsc_pkg::member_t        pm, dm;
    fsc_pkg::weight_t        pf0_reg, pf1_reg, df0_reg, df1_reg;
    fsc_pkg::label_t         lab2_reg  [4];
    fsc_pkg::label_t         lab2_next [4];

    always_comb
    begin
        pm = fsc_pkg::membership(p1_reg);
        dm = fsc_pkg::membership(d1_reg);
        lab2_next[0] = fsc_pkg::rule_label(pm.seg - 3'd1, dm.seg - 3'd1);
        lab2_next[1] = fsc_pkg::rule_label(pm.seg,        dm.seg - 3'd1);
        lab2_next[2] = fsc_pkg::rule_label(pm.seg - 3'd1, dm.seg);
        lab2_next[3] = fsc_pkg::rule_label(pm.seg,        dm.seg);
    end

    // ------------------------------------------------------------------
    // Stage 3: min strengths, then drop the weaker of rules that share
    // a label. Pairs go in order, each seeing the earlier drops; on a tie
    // drop the earlier rule.
    // ------------------------------------------------------------------
    logic             v3_reg;
    fsc_pkg::weight_t w3_reg  [4];
    fsc_pkg::weight_t w3_next [4];
    fsc_pkg::label_t  lab3_reg [4];

    always_comb
    begin
        w3_next[0] = (pf0_reg <= df0_reg) ? pf0_reg : df0_reg;
        w3_next[1] = (pf1_reg <= df0_reg) ? pf1_reg : df0_reg;
        w3_next[2] = (pf0_reg <= df1_reg) ? pf0_reg : df1_reg;
        w3_next[3] = (pf1_reg <= df1_reg) ? pf1_reg : df1_reg;
        for (int a = 0; a < 3; a++) begin
            for (int b = a + 1; b < 4; b++) begin
                if (lab2_reg[a] == lab2_reg[b]) begin
                    if (w3_next[a] > w3_next[b]) begin
                        w3_next[b] = '0;
                    end else begin
                        w3_next[a] = '0;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: weight times singleton level.
    // ------------------------------------------------------------------
    logic             v4_reg;
    logic [15:0]      prod4_reg  [4];
    logic [15:0]      prod4_next [4];
    fsc_pkg::weight_t w4_reg     [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++) begin
            prod4_next[i] = 16'(w3_reg[i]) *
                            16'(fsc_pkg::speed_level(table_sel_reg, lab3_reg[i]));
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: numerator and denominator sums.
    // ------------------------------------------------------------------
    logic             v5_reg;
    fsc_pkg::div_in_t sum5_reg, sum5_next;

    always_comb
    begin
        sum5_next.num = fsc_pkg::NumW'(prod4_reg[0]) + fsc_pkg::NumW'(prod4_reg[1])
                      + fsc_pkg::NumW'(prod4_reg[2]) + fsc_pkg::NumW'(prod4_reg[3]);
        sum5_next.den = fsc_pkg::DenW'(w4_reg[0]) + fsc_pkg::DenW'(w4_reg[1])
                      + fsc_pkg::DenW'(w4_reg[2]) + fsc_pkg::DenW'(w4_reg[3]);
    end

    // Valid bits advance with the data every cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        p1_reg   <= p1_next;
        d1_reg   <= d1_next;
        pf0_reg  <= pm.low_w;
        pf1_reg  <= fsc_pkg::weight_t'(fsc_pkg::WeightFull) - pm.low_w;
        df0_reg  <= dm.low_w;
        df1_reg  <= fsc_pkg::weight_t'(fsc_pkg::WeightFull) - dm.low_w;
        lab2_reg <= lab2_next;
        w3_reg   <= w3_next;
        lab3_reg <= lab2_reg;
        prod4_reg <= prod4_next;
        w4_reg   <= w3_reg;
        sum5_reg <= sum5_next;
    end

    // ------------------------------------------------------------------
    // Stages 6..8: truncating division; its last register drives the
    // result ports.
    // ------------------------------------------------------------------
    fsc_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .in_data   (sum5_reg),
        .out_valid (done),
        .quotient  (speed)
    );

    // The average of singleton levels stays inside the level range.
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (speed >= 9'd250 && speed <= 9'd440))
        else $error("speed outside the singleton level range");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 8))
        else $error("result without a start eight cycles earlier");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised on a pipeline that never stalls");

endmodule

// ===== bench/fuzzy_speed_controller_test.sv =====
// ----------------------------------------------------------------------------
// fuzzy_speed_controller_test
// Self-checking bench for the fuzzy speed controller. A queue of speed
// requests and table-select writes is filled up front; a clocked driver
// feeds it through the start/busy and cfg_valid/cfg_ready handshakes, and a
// clocked monitor compares every done strobe with a locally predicted speed.
// ----------------------------------------------------------------------------
module fuzzy_speed_controller_test;

    // Rule labels, indexed [curve segment][blank-row segment].
    localparam logic [0:6][0:6][2:0] SPEED_LABEL = {
        3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1,
        3'd5, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1,
        3'd4, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1, 3'd0,
        3'd3, 3'd3, 3'd3, 3'd2, 3'd1, 3'd1, 3'd0,
        3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd0, 3'd0,
        3'd2, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0, 3'd0,
        3'd1, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
    };

    // Singleton speed levels, indexed [table select][label].
    localparam logic [0:3][0:6][8:0] SPEED_LEVEL = {
        9'd250, 9'd260, 9'd270, 9'd275, 9'd295, 9'd350, 9'd380,
        9'd260, 9'd270, 9'd275, 9'd290, 9'd300, 9'd360, 9'd400,
        9'd265, 9'd275, 9'd285, 9'd300, 9'd310, 9'd380, 9'd430,
        9'd270, 9'd275, 9'd285, 9'd305, 9'd320, 9'd390, 9'd440
    };

    localparam int RUN_LIMIT   = 500000;   // time units, far above a clean run
    localparam int DRAIN_CYCLES = 20;

    // One pending transfer: either a speed request or a table-select write.
    typedef struct {
        bit                 is_write;
        logic [1:0]         table_sel;
        logic signed [15:0] curve;
        logic [7:0]         rows;
        int                 gap_pct;
    } speed_request_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] curve_measure = '0;
    logic [7:0]         row_count = '0;
    logic               done;
    logic [8:0]         speed;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_data = '0;

    speed_request_t request_queue[$];
    logic [8:0]     speed_expected[$];
    logic [1:0]     level_sel = 2'd0;    // bench copy of the table select
    int             error_count = 0;

    fuzzy_speed_controller dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .curve_measure (curve_measure),
        .row_count     (row_count),
        .done          (done),
        .speed         (speed),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Give the segment (1..6) and lower weight of a scaled value on 0..100.
    function automatic void grade_point(input int x, output int seg, output int lower);
        if (x <= 0)
        begin
            seg   = 1;
            lower = fsc_pkg::WeightFull;
        end
        else if (x >= 6 * fsc_pkg::PointStep)
        begin
            seg   = 6;
            lower = 0;
        end
        else
        begin
            seg   = (x + fsc_pkg::PointStep - 1) / fsc_pkg::PointStep;
            lower = (fsc_pkg::WeightFull * (seg * fsc_pkg::PointStep - x))
                    / fsc_pkg::PointStep;
        end
    endfunction

    function automatic int min_weight(int a, int b);
        return (a <= b) ? a : b;
    endfunction

    // Work out the defuzzified speed for one request under a table select.
    function automatic logic [8:0] predict_speed(logic signed [15:0] curve,
                                                 logic [7:0] rows, logic [1:0] sel);
        int c;
        int blank;
        int p;
        int d;
        int p_seg;
        int p_lo;
        int d_seg;
        int d_lo;
        int num;
        int den;
        int lab[4];
        int w[4];
        c = curve;
        if (c < fsc_pkg::CurveLo)
            c = fsc_pkg::CurveLo;
        else if (c > fsc_pkg::CurveHi)
            c = fsc_pkg::CurveHi;
        p = ((c - fsc_pkg::CurveLo) * 100) / (fsc_pkg::CurveHi - fsc_pkg::CurveLo);

        blank = fsc_pkg::RowBase - int'(rows);
        if (blank < 0)
            blank = 0;
        else if (blank > fsc_pkg::BlankMax)
            blank = fsc_pkg::BlankMax;
        d = blank * 2;

        grade_point(p, p_seg, p_lo);
        grade_point(d, d_seg, d_lo);

        // Fire the four neighbouring rules in their fixed order.
        lab[0] = SPEED_LABEL[p_seg - 1][d_seg - 1];
        lab[1] = SPEED_LABEL[p_seg][d_seg - 1];
        lab[2] = SPEED_LABEL[p_seg - 1][d_seg];
        lab[3] = SPEED_LABEL[p_seg][d_seg];
        w[0] = min_weight(p_lo, d_lo);
        w[1] = min_weight(fsc_pkg::WeightFull - p_lo, d_lo);
        w[2] = min_weight(p_lo, fsc_pkg::WeightFull - d_lo);
        w[3] = min_weight(fsc_pkg::WeightFull - p_lo, fsc_pkg::WeightFull - d_lo);

        // Drop the weaker rule of each pair sharing a label; on a tie drop
        // the earlier one. Later pairs see earlier drops.
        for (int a = 0; a < 3; a++)
            for (int b = a + 1; b < 4; b++)
                if (lab[a] == lab[b])
                begin
                    if (w[a] > w[b])
                        w[b] = 0;
                    else
                        w[a] = 0;
                end

        num = 0;
        den = 0;
        for (int i = 0; i < 4; i++)
        begin
            num += w[i] * int'(SPEED_LEVEL[sel][lab[i]]);
            den += w[i];
        end
        return (den != 0) ? 9'(num / den) : 9'd0;
    endfunction

    task automatic add_speed_request(logic signed [15:0] curve, logic [7:0] rows, int gap);
        speed_request_t r;
        r.is_write  = 1'b0;
        r.table_sel = '0;
        r.curve     = curve;
        r.rows      = rows;
        r.gap_pct   = gap;
        request_queue.push_back(r);
    endtask

    task automatic add_table_write(logic [1:0] sel);
        speed_request_t r;
        r.is_write  = 1'b1;
        r.table_sel = sel;
        r.curve     = '0;
        r.rows      = '0;
        r.gap_pct   = 0;
        request_queue.push_back(r);
    endtask

    // Mostly aim at the clamp windows so every membership segment is hit;
    // the rest spans the full field widths to toggle every bit.
    task automatic add_random_request(int gap);
        logic signed [15:0] curve;
        logic [7:0]         rows;
        if ($urandom_range(99) < 30)
            curve = 16'($urandom);
        else
            curve = 16'($urandom_range(260, 90));
        if ($urandom_range(99) < 30)
            rows = 8'($urandom);
        else
            rows = 8'($urandom_range(150, 85));
        add_speed_request(curve, rows, gap);
    endtask

    // Driver: advance the request queue through the two handshakes.
    // Hold table writes until every outstanding speed has come back.
    always @(posedge clk)
    begin : drive_requests
        logic           slot_free;
        logic           write_open;
        speed_request_t head;
        if (rst_n)
        begin
            slot_free  = !start;
            write_open = cfg_valid && !cfg_ready;

            if (start && !busy)
            begin
                speed_expected.push_back(predict_speed(curve_measure, row_count, level_sel));
                slot_free = 1'b1;
            end

            if (cfg_valid && cfg_ready)
            begin
                level_sel = cfg_data;
                cfg_valid <= 1'b0;
            end
            else if (!cfg_valid && slot_free && request_queue.size() != 0
                     && request_queue[0].is_write && speed_expected.size() == 0)
            begin
                head = request_queue.pop_front();
                cfg_valid  <= 1'b1;
                cfg_data   <= head.table_sel;
                write_open = 1'b1;
            end

            if (slot_free)
            begin
                if (!write_open && request_queue.size() != 0 && !request_queue[0].is_write
                    && $urandom_range(99) >= request_queue[0].gap_pct)
                begin
                    head = request_queue.pop_front();
                    start         <= 1'b1;
                    curve_measure <= head.curve;
                    row_count     <= head.rows;
                end
                else
                begin
                    // Idle: drop start and put noise on the payload.
                    start         <= 1'b0;
                    curve_measure <= 16'($urandom);
                    row_count     <= 8'($urandom);
                end
            end
        end
    end

    // Monitor: take each done strobe and check it against the oldest speed.
    always @(posedge clk)
    begin : check_speeds
        logic [8:0] want;
        if (rst_n && done)
        begin
            if (speed_expected.size() == 0)
            begin
                $error("speed: expected none, actual %0d", speed);
                error_count++;
            end
            else
            begin
                want = speed_expected.pop_front();
                if (speed !== want)
                begin
                    $error("speed: expected %0d, actual %0d", want, speed);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        // Directed requests under the reset table: clamp extremes, segment
        // boundaries, equal-weight ties and rules that share a label.
        add_speed_request(-16'sd32768, 8'd0,   0);
        add_speed_request(16'sd32767,  8'd255, 0);
        add_speed_request(16'sd0,      8'd144, 0);
        add_speed_request(16'sd99,     8'd145, 0);
        add_speed_request(16'sd100,    8'd143, 0);
        add_speed_request(16'sd101,    8'd94,  0);
        add_speed_request(16'sd250,    8'd93,  0);
        add_speed_request(16'sd251,    8'd96,  0);
        add_speed_request(16'sd124,    8'd136, 0);
        add_speed_request(16'sd243,    8'd95,  0);
        add_speed_request(16'sd244,    8'd136, 0);
        add_speed_request(16'sd112,    8'd140, 0);
        add_speed_request(16'sd175,    8'd119, 0);
        add_speed_request(16'sd148,    8'd128, 0);
        add_speed_request(16'sd196,    8'd112, 0);
        add_speed_request(16'sd220,    8'd104, 0);
        add_speed_request(16'sd130,    8'd132, 0);
        add_speed_request(16'sd236,    8'd100, 0);
        add_speed_request(-16'sd1,     8'd128, 0);
        add_speed_request(16'sd16384,  8'd1,   0);
        add_speed_request(16'sd160,    8'd124, 0);

        // Random phases, each behind a table write; walk both extremes of
        // the select. Sender gaps: 29 percent, then 51, then none.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: add_table_write(2'd3);
                1: add_table_write(2'd1);
                2: add_table_write(2'd2);
                3: add_table_write(2'd0);
                4: add_table_write(2'd3);
                default: add_table_write(2'd1);
            endcase
            repeat (155)
                add_random_request((ph < 2) ? 29 : ((ph < 4) ? 51 : 0));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || start || cfg_valid)
            @(posedge clk);
        // Let the pipeline drain, then flag anything still owed.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (speed_expected.size() != 0)
        begin
            $error("speed: %0d results never arrived", speed_expected.size());
            error_count++;
        end

        if (error_count == 0)
            $display("fuzzy_speed_controller_test: done, clean");
        else
            $display("fuzzy_speed_controller_test: done, errors");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("fuzzy_speed_controller_test: done, errors");
        $finish;
    end

endmodule
